// ----- rtl/bba_pkg.sv -----
// ---------------------------------------------------------------------------
// Buddy block allocator package
// Word types of the request and result channels and the function codes.
// ---------------------------------------------------------------------------
package bba_pkg;

  // Function codes of a request word.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // One request word.
  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [6:0]  free_node;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        ok;
    logic [6:0]  node_number;
    logic [11:0] block_offset;
    logic [12:0] block_bytes;
  } out_word_t;

endpackage

// ----- rtl/buddy_block_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// Buddy block allocator unit
// Hands out and takes back power-of-two blocks of a region of TL times
// LEAF_BYTES bytes (TL is LEAVES rounded down to a power of two), kept as
// a heap-numbered binary tree (root is node 1). An allocate word gets the
// leftmost free block of the smallest size that covers the request; a
// free word clears the mark of one node. Each tree node keeps its in-use
// mark and the shallowest level at which its subtree still has a free
// block, in one RAM, and a single merge unit updates these figures one
// level per cycle. After reset a clearing pass writes all 2*TL-1 nodes,
// one per cycle, before the first word is taken. An allocate runs the size
// search, the root read, the descent and the walk back up, one level per
// cycle each. One word is in work at a time.
// ---------------------------------------------------------------------------
module buddy_block_allocator_unit #(
  parameter int unsigned LEAF_BYTES = 64,
  parameter int unsigned LEAVES     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bba_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bba_pkg::out_word_t  out_data
);

  import bba_pkg::*;

  function automatic int unsigned floor_pow2(input int unsigned v);
    int unsigned p;
    p = 1;
    while (p * 2 <= v) begin
      p = p * 2;
    end
    return p;
  endfunction

  localparam int unsigned     TL       = floor_pow2(LEAVES);
  localparam int unsigned     NODES    = 2 * TL;
  localparam int              AW       = $clog2(NODES);
  localparam int              L        = $clog2(TL);
  localparam int              DW       = $clog2(L + 2);
  localparam int              W        = DW + 1;
  localparam longint unsigned REGION   = longint'(TL) * longint'(LEAF_BYTES);
  localparam int              RW       = $clog2(REGION + 1);
  localparam int              CW       = (RW > 17) ? RW : 17;

  localparam logic [DW-1:0]   NONE     = DW'(L + 1);
  localparam logic [DW-1:0]   LEAF_LEV = DW'(L);
  localparam logic [CW-1:0]   REGION_V = CW'(REGION);
  localparam logic [CW-1:0]   LEAF_V   = CW'(LEAF_BYTES);
  localparam logic [AW-1:0]   ROOT     = AW'(1);
  localparam logic [AW-1:0]   LAST     = AW'(NODES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SIZE  = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DESC  = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_UP    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_n_r, clr_n_nxt;
  logic [DW-1:0] clr_lev_r, clr_lev_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] blk_r, blk_nxt;
  logic [CW-1:0] dblk_r, dblk_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [DW-1:0] lev_r, lev_nxt;
  logic [DW-1:0] chb_r, chb_nxt;
  logic [11:0]   off_r, off_nxt;
  out_word_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [AW-1:0] ram_ra0, ram_ra1;
  logic [W-1:0]  ram_rd0, ram_rd1;

  logic          m_busy;
  logic [DW-1:0] m_lev, m_b0, m_b1, m_best;

  logic [CW-1:0] req_size;
  logic [DW-1:0] fn_lev;
  logic [AW-1:0] fn;
  logic          fn_ok;
  logic          go_left;
  logic [CW-1:0] half_blk;
  logic [AW-1:0] new_cur;
  logic [11:0]   new_off;
  logic [AW-1:0] par;
  logic [AW-1:0] clr_next;

  // Node store: one word per node, {in-use mark, best free level}.
  bba_ram #(
    .WIDTH (W),
    .DEPTH (NODES)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_ra0),
    .raddr1 (ram_ra1),
    .rdata0 (ram_rd0),
    .rdata1 (ram_rd1)
  );

  // Shared merge unit for the free step and the walk up the tree.
  bba_merge #(
    .DW   (DW),
    .NONE (L + 1)
  ) u_merge (
    .par_busy (m_busy),
    .par_lev  (m_lev),
    .b0       (m_b0),
    .b1       (m_b1),
    .best     (m_best)
  );

  // Request size raised to one leaf, and the node to free with its level.
  always_comb begin
    req_size = (CW'(in_data.request_bytes) < LEAF_V) ? LEAF_V
                                                     : CW'(in_data.request_bytes);
    fn_ok    = (in_data.free_node != 7'd0) && (32'(in_data.free_node) < NODES);
    fn       = AW'(in_data.free_node);
    fn_lev   = '0;
    for (int i = 0; i < 7; i++) begin
      if (in_data.free_node[i]) begin
        fn_lev = DW'(i);
      end
    end
  end

  // Descent step: the left child is taken when it still offers a block.
  assign go_left  = (ram_rd0[DW-1:0] <= d_r);
  assign half_blk = dblk_r >> 1;
  assign new_cur  = {cur_r[AW-2:0], ~go_left};
  assign new_off  = go_left ? off_r : off_r + half_blk[11:0];
  assign par      = cur_r >> 1;
  assign clr_next = clr_n_r + AW'(1);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_n_nxt     = clr_n_r;
    clr_lev_nxt   = clr_lev_r;
    size_nxt      = size_r;
    blk_nxt       = blk_r;
    dblk_nxt      = dblk_r;
    d_nxt         = d_r;
    cur_nxt       = cur_r;
    lev_nxt       = lev_r;
    chb_nxt       = chb_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;
    ram_ra0       = cur_r;
    ram_ra1       = cur_r;
    m_busy        = 1'b0;
    m_lev         = lev_r;
    m_b0          = chb_r;
    m_b1          = ram_rd0[DW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Write every node as free, one per cycle.
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_n_r;
        ram_wdata = {1'b0, clr_lev_r};
        if (clr_n_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_n_nxt = clr_next;
          if ((clr_next & clr_n_r) == '0) begin
            clr_lev_nxt = clr_lev_r + DW'(1);
          end
        end
      end

      // Take a word and start either the size search or the free.
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_data.func == FUNC_FREE) begin
            if (fn_ok) begin
              res_nxt.ok          = 1'b1;
              res_nxt.node_number = in_data.free_node;
              cur_nxt             = fn;
              lev_nxt             = fn_lev;
              ram_ra0             = {fn[AW-2:0], 1'b0};
              ram_ra1             = {fn[AW-2:0], 1'b1};
              state_nxt           = S_FREE;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            if (req_size > REGION_V) begin
              state_nxt = S_DONE;
            end else begin
              size_nxt  = req_size;
              blk_nxt   = REGION_V;
              d_nxt     = '0;
              state_nxt = S_SIZE;
            end
          end
        end
      end

      // Halve the block while it still covers the request.
      S_SIZE: begin
        if ((d_r < LEAF_LEV) && ((blk_r >> 1) >= size_r)) begin
          blk_nxt = blk_r >> 1;
          d_nxt   = d_r + DW'(1);
        end else begin
          ram_ra0   = ROOT;
          state_nxt = S_ROOT;
        end
      end

      // Check the root for any block at the wanted level.
      S_ROOT: begin
        if (ram_rd0[DW-1:0] > d_r) begin
          state_nxt = S_DONE;
        end else if (d_r == '0) begin
          ram_we                = 1'b1;
          ram_waddr             = ROOT;
          ram_wdata             = {1'b1, NONE};
          res_nxt.ok            = 1'b1;
          res_nxt.node_number   = 7'(ROOT);
          res_nxt.block_offset  = '0;
          res_nxt.block_bytes   = 13'(blk_r);
          state_nxt             = S_DONE;
        end else begin
          cur_nxt   = ROOT;
          lev_nxt   = '0;
          dblk_nxt  = REGION_V;
          off_nxt   = '0;
          ram_ra0   = {ROOT[AW-2:0], 1'b0};
          state_nxt = S_DESC;
        end
      end

      // Step down one level toward the leftmost free block.
      S_DESC: begin
        cur_nxt  = new_cur;
        lev_nxt  = lev_r + DW'(1);
        dblk_nxt = half_blk;
        off_nxt  = new_off;
        if (lev_r + DW'(1) == d_r) begin
          ram_we               = 1'b1;
          ram_waddr            = new_cur;
          ram_wdata            = {1'b1, NONE};
          res_nxt.ok           = 1'b1;
          res_nxt.node_number  = 7'(new_cur);
          res_nxt.block_offset = new_off;
          res_nxt.block_bytes  = 13'(blk_r);
          chb_nxt              = NONE;
          ram_ra0              = new_cur ^ AW'(1);
          ram_ra1              = new_cur >> 1;
          state_nxt            = S_UP;
        end else begin
          ram_ra0 = {new_cur[AW-2:0], 1'b0};
        end
      end

      // Clear the mark and recompute the node from its children.
      S_FREE: begin
        m_busy    = 1'b0;
        m_lev     = lev_r;
        m_b0      = (lev_r == LEAF_LEV) ? lev_r + DW'(1) : ram_rd0[DW-1:0];
        m_b1      = (lev_r == LEAF_LEV) ? lev_r + DW'(1) : ram_rd1[DW-1:0];
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {1'b0, m_best};
        if (cur_r == ROOT) begin
          state_nxt = S_DONE;
        end else begin
          chb_nxt   = m_best;
          ram_ra0   = cur_r ^ AW'(1);
          ram_ra1   = cur_r >> 1;
          state_nxt = S_UP;
        end
      end

      // Walk up: sibling and parent words arrive, the parent is rewritten.
      S_UP: begin
        m_busy    = ram_rd1[DW];
        m_lev     = lev_r - DW'(1);
        m_b0      = chb_r;
        m_b1      = ram_rd0[DW-1:0];
        ram_we    = 1'b1;
        ram_waddr = par;
        ram_wdata = {ram_rd1[DW], m_best};
        cur_nxt   = par;
        lev_nxt   = lev_r - DW'(1);
        chb_nxt   = m_best;
        if (par == ROOT) begin
          state_nxt = S_DONE;
        end else begin
          ram_ra0 = par ^ AW'(1);
          ram_ra1 = par >> 1;
        end
      end

      // Hand the result word to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_n_r     <= ROOT;
      clr_lev_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_n_r     <= clr_n_nxt;
      clr_lev_r   <= clr_lev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    blk_r      <= blk_nxt;
    dblk_r     <= dblk_nxt;
    d_r        <= d_nxt;
    cur_r      <= cur_nxt;
    lev_r      <= lev_nxt;
    chb_r      <= chb_nxt;
    off_r      <= off_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The descent never passes the level chosen by the size search.
  a_desc_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC) |-> (lev_r < d_r))
    else $error("descent went past the chosen level");

  // The walk up always starts below the root.
  a_up_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (cur_r != ROOT))
    else $error("walk up started at the root");

  // The node store is never written while the block waits for a word.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("node store written while idle");

  // A failed word carries all-zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.ok) |->
      (out_data_r.node_number == 7'd0 && out_data_r.block_offset == 12'd0 &&
       out_data_r.block_bytes == 13'd0))
    else $error("failed result word has nonzero fields");

endmodule

// ----- rtl/bba_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/bba_merge.sv -----
// ---------------------------------------------------------------------------
// Buddy node merge unit
// Works out the shallowest level at which a node's subtree holds a block
// that can be granted, from its own mark and the figures of its children.
// ---------------------------------------------------------------------------
module bba_merge #(
  parameter int DW   = 3,
  parameter int NONE = 7
) (
  input  logic          par_busy,
  input  logic [DW-1:0] par_lev,
  input  logic [DW-1:0] b0,
  input  logic [DW-1:0] b1,
  output logic [DW-1:0] best
);

  logic [DW-1:0] kid_lev;

  assign kid_lev = par_lev + DW'(1);

  // A marked node offers nothing; two fully clear children make the node
  // itself available; otherwise the better child wins.
  always_comb begin
    priority if (par_busy) begin
      best = DW'(NONE);
    end else if (b0 == kid_lev && b1 == kid_lev) begin
      best = par_lev;
    end else begin
      best = (b0 < b1) ? b0 : b1;
    end
  end

endmodule
